// ===== sv/slbm_pkg.sv =====
// Package for the serially loaded bank mapper: beat types, target codes,
// configuration register indexes and reset values.
// No dependencies.
package slbm_pkg;

    // Field widths
    localparam int unsigned AddrW     = 16;
    localparam int unsigned ByteW     = 8;
    localparam int unsigned MapAddrW  = 18;
    localparam int unsigned ChrAddrW  = 17;
    localparam int unsigned BankW     = 5;
    localparam int unsigned CountW    = 3;
    localparam int unsigned CfgIndexW = 2;
    localparam int unsigned CfgDataW  = 18;

    // Access kinds: bit 0 = write, bit 1 = PPU side
    typedef enum logic [1:0] {
        KIND_CPU_READ  = 2'd0,
        KIND_CPU_WRITE = 2'd1,
        KIND_PPU_READ  = 2'd2,
        KIND_PPU_WRITE = 2'd3
    } kind_t;

    // Memory targets
    typedef enum logic [2:0] {
        TGT_NONE      = 3'd0,
        TGT_ZERO      = 3'd1,
        TGT_PRG_ROM   = 3'd2,
        TGT_PRG_RAM   = 3'd3,
        TGT_CHR       = 3'd4,
        TGT_NAMETABLE = 3'd5,
        TGT_PALETTE   = 3'd6,
        TGT_UNUSED    = 3'd7
    } target_t;

    // Configuration register indexes
    typedef enum logic [CfgIndexW-1:0] {
        CFG_PRG_ROM_MASK = 2'd0,
        CFG_CHR_MASK     = 2'd1,
        CFG_CHR_IS_RAM   = 2'd2,
        CFG_NONE         = 2'd3
    } cfg_index_t;

    // Mapper register select, bus address bits 14:13
    typedef enum logic [1:0] {
        SEL_CONTROL  = 2'd0,
        SEL_CHR_LOW  = 2'd1,
        SEL_CHR_HIGH = 2'd2,
        SEL_PRG_BANK = 2'd3
    } reg_sel_t;

    // Mirroring modes, control bits 1:0
    typedef enum logic [1:0] {
        MIR_SINGLE_LOW  = 2'd0,
        MIR_SINGLE_HIGH = 2'd1,
        MIR_VERTICAL    = 2'd2,
        MIR_HORIZONTAL  = 2'd3
    } mirror_t;

    // Reset values
    localparam logic [MapAddrW-1:0] PrgRomMaskReset = 18'h3ffff;
    localparam logic [ChrAddrW-1:0] ChrMaskReset    = 17'h01fff;
    localparam logic [BankW-1:0]    ControlReset    = 5'h0c;
    localparam logic [BankW-1:0]    ChrLowReset     = 5'h00;
    localparam logic [BankW-1:0]    ChrHighReset    = 5'h01;
    localparam logic [BankW-1:0]    PrgBankReset    = 5'h0f;
    localparam logic [BankW-1:0]    ControlForceSet = 5'h0c;
    localparam logic [CountW-1:0]   ShiftLoadCount  = 3'd5;
    localparam logic [3:0]          PrgLastBank     = 4'hf;
    localparam logic [AddrW-1:0]    PaletteBase     = 16'h3f00;

    // One input beat
    typedef struct packed {
        logic [1:0]       kind;
        logic [AddrW-1:0] bus_addr;
        logic [ByteW-1:0] write_value;
    } in_beat_t;

    // One result beat
    typedef struct packed {
        target_t             target;
        logic [MapAddrW-1:0] mapped_addr;
        logic                write_enable;
        logic [ByteW-1:0]    write_byte;
    } out_beat_t;

endpackage

// ===== sv/serial_loaded_bank_mapper.sv =====
// Serially loaded bank mapper: CPU/PPU access decode and bank translation.
// Holds the serial shift register and bank registers.
// Depends on slbm_pkg.
//
// Usage:
//   s_valid/s_ready/s_data carry one bus access per beat (kind, bus_addr,
//   write_value). m_valid/m_ready/m_data return one result beat per access:
//   the target memory, the translated address and the write strobe/byte.
//   cfg_we/cfg_index/cfg_wdata write the size masks and the CHR RAM flag;
//   writes take effect at the clock edge; the user must make them only while
//   idle, since the block does not enforce it.
// Path: an access passes the input register, then the result register.
// Throughput: one access per cycle when not stalled; the decode and bank
//   select sit between the two registers, and a serial write updates the bank
//   registers as it moves to the result register, so the next access sees it.
// Reset (aresetn low, synchronous): pipeline empties, bank registers take
//   their power-up values (control 0x0c, PRG bank 0x0f, CHR banks 0 and 1),
//   masks return to full PRG and 8K CHR, CHR is ROM.
// Stall: while m_ready is low the result register holds; the input register
//   still takes one more beat, then s_ready drops until the result leaves.
module serial_loaded_bank_mapper (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    // access channel
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  slbm_pkg::in_beat_t                   s_data,
    // result channel
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output slbm_pkg::out_beat_t                  m_data,
    // configuration write port
    input  logic                                 cfg_we,
    input  logic [slbm_pkg::CfgIndexW-1:0]       cfg_index,
    input  logic [slbm_pkg::CfgDataW-1:0]        cfg_wdata
);

    // Pipeline registers
    logic                s1_valid_reg, s1_valid_next;
    slbm_pkg::in_beat_t  s1_data_reg;
    logic                m_valid_reg, m_valid_next;
    slbm_pkg::out_beat_t m_data_reg, m_data_next;

    // Configuration
    logic [slbm_pkg::MapAddrW-1:0] prg_rom_mask_reg, prg_rom_mask_next;
    logic [slbm_pkg::ChrAddrW-1:0] chr_mask_reg, chr_mask_next;
    logic                          chr_is_ram_reg, chr_is_ram_next;

    // Mapper state
    logic [slbm_pkg::BankW-1:0]  shift_bits_reg, shift_bits_next;
    logic [slbm_pkg::CountW-1:0] shift_count_reg, shift_count_next;
    logic [slbm_pkg::BankW-1:0]  control_reg, control_next;
    logic [slbm_pkg::BankW-1:0]  chr_low_bank_reg, chr_low_bank_next;
    logic [slbm_pkg::BankW-1:0]  chr_high_bank_reg, chr_high_bank_next;
    logic [slbm_pkg::BankW-1:0]  prg_bank_reg, prg_bank_next;

    // Decode helpers
    logic                          advance;
    logic                          is_write, is_ppu;
    logic [slbm_pkg::AddrW-1:0]    addr;
    logic [slbm_pkg::ByteW-1:0]    wval;
    logic [3:0]                    rom_bank;
    logic [slbm_pkg::MapAddrW-1:0] rom_addr;
    logic [slbm_pkg::ChrAddrW-1:0] chr_addr;
    logic [10:0]                   nt_addr;
    logic [slbm_pkg::BankW-1:0]    shifted;
    logic [slbm_pkg::CountW-1:0]   count_inc;
    slbm_pkg::out_beat_t           res;

    // Handshake: stage 1 moves on when the result register is free
    assign advance = s1_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready = !s1_valid_reg || advance;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    always_comb begin
        s1_valid_next = s_ready ? s_valid : s1_valid_reg;
        if (advance) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    // Field aliases
    assign is_write = s1_data_reg.kind[0];
    assign is_ppu   = s1_data_reg.kind[1];
    assign addr     = s1_data_reg.bus_addr;
    assign wval     = s1_data_reg.write_value;
    assign rom_bank = prg_bank_reg[3:0];

    // PRG ROM translation: 32K mode drops the low bank bit
    always_comb begin
        if (!control_reg[3]) begin
            rom_addr = {rom_bank[3:1], addr[14:0]};
        end else if (!control_reg[2]) begin
            rom_addr = addr[14] ? {rom_bank, addr[13:0]} : {4'h0, addr[13:0]};
        end else begin
            rom_addr = addr[14] ? {slbm_pkg::PrgLastBank, addr[13:0]}
                                : {rom_bank, addr[13:0]};
        end
        rom_addr = rom_addr & prg_rom_mask_reg;
    end

    // CHR translation: 8K mode drops the low bank bit
    always_comb begin
        if (!control_reg[4]) begin
            chr_addr = {chr_low_bank_reg[4:1], addr[12:0]};
        end else if (!addr[12]) begin
            chr_addr = {chr_low_bank_reg, addr[11:0]};
        end else begin
            chr_addr = {chr_high_bank_reg, addr[11:0]};
        end
        chr_addr = chr_addr & chr_mask_reg;
    end

    // Nametable mirroring
    always_comb begin
        unique case (slbm_pkg::mirror_t'(control_reg[1:0]))
            slbm_pkg::MIR_SINGLE_LOW:  nt_addr = {1'b0, addr[9:0]};
            slbm_pkg::MIR_SINGLE_HIGH: nt_addr = {1'b1, addr[9:0]};
            slbm_pkg::MIR_VERTICAL:    nt_addr = {addr[10], addr[9:0]};
            slbm_pkg::MIR_HORIZONTAL:  nt_addr = {addr[11], addr[9:0]};
            default:                   nt_addr = {1'b0, addr[9:0]};
        endcase
    end

    // Access decode into the result beat
    always_comb begin
        res.target       = slbm_pkg::TGT_NONE;
        res.mapped_addr  = '0;
        res.write_enable = 1'b0;
        if (!is_ppu) begin
            if (addr[15:13] == 3'b011) begin
                if (!prg_bank_reg[4]) begin
                    res.target       = slbm_pkg::TGT_PRG_RAM;
                    res.mapped_addr  = {5'b0, addr[12:0]};
                    res.write_enable = is_write;
                end else if (!is_write) begin
                    res.target = slbm_pkg::TGT_ZERO;
                end
            end else if (addr[15] && !is_write) begin
                res.target      = slbm_pkg::TGT_PRG_ROM;
                res.mapped_addr = rom_addr;
            end
        end else begin
            if (addr[15:13] == 3'b000) begin
                if (!is_write || chr_is_ram_reg) begin
                    res.target       = slbm_pkg::TGT_CHR;
                    res.mapped_addr  = {1'b0, chr_addr};
                    res.write_enable = is_write;
                end
            end else if (addr < slbm_pkg::PaletteBase) begin
                res.target       = slbm_pkg::TGT_NAMETABLE;
                res.mapped_addr  = {7'b0, nt_addr};
                res.write_enable = is_write;
            end else begin
                res.target       = slbm_pkg::TGT_PALETTE;
                res.mapped_addr  = {2'b0, addr};
                res.write_enable = is_write;
            end
        end
        res.write_byte = res.write_enable ? wval : '0;
        m_data_next    = advance ? res : m_data_reg;
    end

    // Serial load of the mapper registers on CPU writes at $8000 and up
    assign shifted   = {wval[0], shift_bits_reg[4:1]};
    assign count_inc = shift_count_reg + 3'd1;

    always_comb begin
        shift_bits_next    = shift_bits_reg;
        shift_count_next   = shift_count_reg;
        control_next       = control_reg;
        chr_low_bank_next  = chr_low_bank_reg;
        chr_high_bank_next = chr_high_bank_reg;
        prg_bank_next      = prg_bank_reg;
        if (advance && !is_ppu && is_write && addr[15]) begin
            if (wval[7]) begin
                shift_count_next = '0;
                control_next     = control_reg | slbm_pkg::ControlForceSet;
            end else begin
                shift_bits_next = shifted;
                if (count_inc == slbm_pkg::ShiftLoadCount) begin
                    shift_count_next = '0;
                    unique case (slbm_pkg::reg_sel_t'(addr[14:13]))
                        slbm_pkg::SEL_CONTROL:  control_next       = shifted;
                        slbm_pkg::SEL_CHR_LOW:  chr_low_bank_next  = shifted;
                        slbm_pkg::SEL_CHR_HIGH: chr_high_bank_next = shifted;
                        slbm_pkg::SEL_PRG_BANK: prg_bank_next      = shifted;
                        default:                prg_bank_next      = shifted;
                    endcase
                end else begin
                    shift_count_next = count_inc;
                end
            end
        end
    end

    // Configuration writes; indexes past the list are ignored
    always_comb begin
        prg_rom_mask_next = prg_rom_mask_reg;
        chr_mask_next     = chr_mask_reg;
        chr_is_ram_next   = chr_is_ram_reg;
        if (cfg_we) begin
            unique case (slbm_pkg::cfg_index_t'(cfg_index))
                slbm_pkg::CFG_PRG_ROM_MASK: prg_rom_mask_next = cfg_wdata;
                slbm_pkg::CFG_CHR_MASK:
                    chr_mask_next = cfg_wdata[slbm_pkg::ChrAddrW-1:0];
                slbm_pkg::CFG_CHR_IS_RAM:   chr_is_ram_next = cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // Registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg      <= 1'b0;
            m_valid_reg       <= 1'b0;
            prg_rom_mask_reg  <= slbm_pkg::PrgRomMaskReset;
            chr_mask_reg      <= slbm_pkg::ChrMaskReset;
            chr_is_ram_reg    <= 1'b0;
            shift_bits_reg    <= '0;
            shift_count_reg   <= '0;
            control_reg       <= slbm_pkg::ControlReset;
            chr_low_bank_reg  <= slbm_pkg::ChrLowReset;
            chr_high_bank_reg <= slbm_pkg::ChrHighReset;
            prg_bank_reg      <= slbm_pkg::PrgBankReset;
        end else begin
            s1_valid_reg      <= s1_valid_next;
            m_valid_reg       <= m_valid_next;
            prg_rom_mask_reg  <= prg_rom_mask_next;
            chr_mask_reg      <= chr_mask_next;
            chr_is_ram_reg    <= chr_is_ram_next;
            shift_bits_reg    <= shift_bits_next;
            shift_count_reg   <= shift_count_next;
            control_reg       <= control_next;
            chr_low_bank_reg  <= chr_low_bank_next;
            chr_high_bank_reg <= chr_high_bank_next;
            prg_bank_reg      <= prg_bank_next;
        end
        if (s_ready) begin
            s1_data_reg <= s_data;
        end
        m_data_reg <= m_data_next;
    end

endmodule

// ===== tb/tb_top.sv =====
// Self-checking bench for serial_loaded_bank_mapper: directed access table, then
// random CPU/PPU traffic under several mask settings, checked against an in-bench mapper.
// Depends on slbm_pkg and the serial_loaded_bank_mapper RTL.
module tb_top;

    localparam int unsigned NumPhases     = 8;
    localparam int unsigned PhaseAccesses = 250;
    localparam int unsigned DrillCount    = 29;
    localparam int unsigned DrainCycles   = 20;
    localparam int unsigned CycleLimit    = 300000;

    logic                                  aclk;
    logic                                  aresetn;
    logic                                  s_valid;
    logic                                  s_ready;
    slbm_pkg::in_beat_t                    s_data;
    logic                                  m_valid;
    logic                                  m_ready;
    slbm_pkg::out_beat_t                   m_data;
    logic                                  cfg_we;
    logic [slbm_pkg::CfgIndexW-1:0]        cfg_index;
    logic [slbm_pkg::CfgDataW-1:0]         cfg_wdata;

    serial_loaded_bank_mapper u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    // Mapper state mirror
    logic [slbm_pkg::BankW-1:0]    sh_bits    = '0;
    logic [slbm_pkg::CountW-1:0]   sh_count   = '0;
    logic [slbm_pkg::BankW-1:0]    ctrl_q     = slbm_pkg::ControlReset;
    logic [slbm_pkg::BankW-1:0]    chr_lo     = slbm_pkg::ChrLowReset;
    logic [slbm_pkg::BankW-1:0]    chr_hi     = slbm_pkg::ChrHighReset;
    logic [slbm_pkg::BankW-1:0]    rom_bank_q = slbm_pkg::PrgBankReset;
    logic [slbm_pkg::MapAddrW-1:0] prg_mask   = slbm_pkg::PrgRomMaskReset;
    logic [slbm_pkg::ChrAddrW-1:0] chr_mask_q = slbm_pkg::ChrMaskReset;
    logic                          chr_ram    = 1'b0;

    slbm_pkg::out_beat_t pending_results [$];
    bit          send_idle = 1'b1;
    bit          recv_idle = 1'b1;
    int unsigned bad_results     = 0;
    int unsigned checked_results = 0;
    int unsigned sent_accesses   = 0;
    int unsigned reg_loads       = 0;
    int unsigned cycles          = 0;

    // Directed access table; typed rows carry a hand-computed result
    typedef struct {
        slbm_pkg::in_beat_t  beat;
        bit                  typed;
        slbm_pkg::out_beat_t want;
    } drill_t;

    drill_t drills [DrillCount] = '{
        // power-up state: control 0x0c, PRG bank 0x0f, CHR ROM, 8K CHR
        '{'{slbm_pkg::KIND_CPU_READ,  16'h0000, 8'h00}, 1'b1,
          '{slbm_pkg::TGT_NONE,      18'h00000, 1'b0, 8'h00}},
        '{'{slbm_pkg::KIND_CPU_WRITE, 16'h5fff, 8'hff}, 1'b1,
          '{slbm_pkg::TGT_NONE,      18'h00000, 1'b0, 8'h00}},
        '{'{slbm_pkg::KIND_CPU_READ,  16'h6000, 8'h00}, 1'b1,
          '{slbm_pkg::TGT_PRG_RAM,   18'h00000, 1'b0, 8'h00}},
        '{'{slbm_pkg::KIND_CPU_WRITE, 16'h7fff, 8'ha5}, 1'b1,
          '{slbm_pkg::TGT_PRG_RAM,   18'h01fff, 1'b1, 8'ha5}},
        '{'{slbm_pkg::KIND_CPU_READ,  16'h8000, 8'h00}, 1'b1,
          '{slbm_pkg::TGT_PRG_ROM,   18'h3c000, 1'b0, 8'h00}},
        '{'{slbm_pkg::KIND_CPU_READ,  16'hffff, 8'h00}, 1'b1,
          '{slbm_pkg::TGT_PRG_ROM,   18'h3ffff, 1'b0, 8'h00}},
        '{'{slbm_pkg::KIND_PPU_READ,  16'h0000, 8'h00}, 1'b1,
          '{slbm_pkg::TGT_CHR,       18'h00000, 1'b0, 8'h00}},
        '{'{slbm_pkg::KIND_PPU_WRITE, 16'h1fff, 8'h3c}, 1'b1,
          '{slbm_pkg::TGT_NONE,      18'h00000, 1'b0, 8'h00}},
        '{'{slbm_pkg::KIND_PPU_READ,  16'h2000, 8'h00}, 1'b1,
          '{slbm_pkg::TGT_NAMETABLE, 18'h00000, 1'b0, 8'h00}},
        '{'{slbm_pkg::KIND_PPU_WRITE, 16'h3eff, 8'hff}, 1'b1,
          '{slbm_pkg::TGT_NAMETABLE, 18'h002ff, 1'b1, 8'hff}},
        '{'{slbm_pkg::KIND_PPU_READ,  16'h3f00, 8'h00}, 1'b1,
          '{slbm_pkg::TGT_PALETTE,   18'h03f00, 1'b0, 8'h00}},
        '{'{slbm_pkg::KIND_PPU_WRITE, 16'hffff, 8'h80}, 1'b1,
          '{slbm_pkg::TGT_PALETTE,   18'h0ffff, 1'b1, 8'h80}},
        // load PRG bank 0x13 (RAM disabled); only the last address selects
        '{'{slbm_pkg::KIND_CPU_WRITE, 16'h8000, 8'h01}, 1'b1,
          '{slbm_pkg::TGT_NONE,      18'h00000, 1'b0, 8'h00}},
        '{'{slbm_pkg::KIND_CPU_WRITE, 16'ha000, 8'h7f}, 1'b1,
          '{slbm_pkg::TGT_NONE,      18'h00000, 1'b0, 8'h00}},
        '{'{slbm_pkg::KIND_CPU_WRITE, 16'hc000, 8'h00}, 1'b1,
          '{slbm_pkg::TGT_NONE,      18'h00000, 1'b0, 8'h00}},
        '{'{slbm_pkg::KIND_CPU_WRITE, 16'hffff, 8'h7e}, 1'b1,
          '{slbm_pkg::TGT_NONE,      18'h00000, 1'b0, 8'h00}},
        '{'{slbm_pkg::KIND_CPU_WRITE, 16'he000, 8'h41}, 1'b1,
          '{slbm_pkg::TGT_NONE,      18'h00000, 1'b0, 8'h00}},
        '{'{slbm_pkg::KIND_CPU_READ,  16'h6000, 8'h00}, 1'b1,
          '{slbm_pkg::TGT_ZERO,      18'h00000, 1'b0, 8'h00}},
        '{'{slbm_pkg::KIND_CPU_WRITE, 16'h6abc, 8'h55}, 1'b1,
          '{slbm_pkg::TGT_NONE,      18'h00000, 1'b0, 8'h00}},
        '{'{slbm_pkg::KIND_CPU_READ,  16'h8000, 8'h00}, 1'b0, '0},
        // load control 0x12: 4K CHR, 32K PRG, vertical mirroring
        '{'{slbm_pkg::KIND_CPU_WRITE, 16'hffff, 8'h00}, 1'b1,
          '{slbm_pkg::TGT_NONE,      18'h00000, 1'b0, 8'h00}},
        '{'{slbm_pkg::KIND_CPU_WRITE, 16'h8000, 8'h01}, 1'b1,
          '{slbm_pkg::TGT_NONE,      18'h00000, 1'b0, 8'h00}},
        '{'{slbm_pkg::KIND_CPU_WRITE, 16'hc000, 8'h02}, 1'b1,
          '{slbm_pkg::TGT_NONE,      18'h00000, 1'b0, 8'h00}},
        '{'{slbm_pkg::KIND_CPU_WRITE, 16'ha000, 8'h7e}, 1'b1,
          '{slbm_pkg::TGT_NONE,      18'h00000, 1'b0, 8'h00}},
        '{'{slbm_pkg::KIND_CPU_WRITE, 16'h9fff, 8'h7f}, 1'b1,
          '{slbm_pkg::TGT_NONE,      18'h00000, 1'b0, 8'h00}},
        // partial shift cut off by a reset write
        '{'{slbm_pkg::KIND_CPU_WRITE, 16'hc000, 8'h01}, 1'b1,
          '{slbm_pkg::TGT_NONE,      18'h00000, 1'b0, 8'h00}},
        '{'{slbm_pkg::KIND_CPU_WRITE, 16'hc000, 8'h80}, 1'b1,
          '{slbm_pkg::TGT_NONE,      18'h00000, 1'b0, 8'h00}},
        '{'{slbm_pkg::KIND_PPU_READ,  16'h1000, 8'h00}, 1'b0, '0},
        '{'{slbm_pkg::KIND_CPU_READ,  16'hc123, 8'h00}, 1'b0, '0}
    };

    // Clock
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Run guard
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CycleLimit) begin
            $display("timeout after %0d cycles, %0d results outstanding", cycles,
                     pending_results.size());
            $display("serial_loaded_bank_mapper: mismatch");
            $finish;
        end
    end

    // Decode one access against the mirrored state; CPU writes at $8000+ advance it
    function automatic slbm_pkg::out_beat_t map_access(slbm_pkg::in_beat_t b);
        slbm_pkg::out_beat_t           r;
        slbm_pkg::kind_t               k;
        logic [slbm_pkg::AddrW-1:0]    a;
        logic                          wr;
        logic [3:0]                    bank16;
        logic [slbm_pkg::MapAddrW-1:0] rom;
        logic [slbm_pkg::ChrAddrW-1:0] chr;
        logic [10:0]                   nt;
        r  = '0;
        k  = slbm_pkg::kind_t'(b.kind);
        a  = b.bus_addr;
        wr = (k == slbm_pkg::KIND_CPU_WRITE) || (k == slbm_pkg::KIND_PPU_WRITE);
        if (k == slbm_pkg::KIND_CPU_READ || k == slbm_pkg::KIND_CPU_WRITE) begin
            if (a >= 16'h6000 && a < 16'h8000) begin
                if (!rom_bank_q[4]) begin
                    r.target       = slbm_pkg::TGT_PRG_RAM;
                    r.mapped_addr  = slbm_pkg::MapAddrW'(a[12:0]);
                    r.write_enable = wr;
                end else if (!wr) begin
                    r.target = slbm_pkg::TGT_ZERO;
                end
            end else if (a >= 16'h8000) begin
                if (wr) begin
                    // serial port: bit 7 resets, else shift in bit 0
                    if (b.write_value[7]) begin
                        sh_count = '0;
                        ctrl_q   = ctrl_q | slbm_pkg::ControlForceSet;
                    end else begin
                        sh_bits  = {b.write_value[0], sh_bits[4:1]};
                        sh_count = sh_count + 1'b1;
                        if (sh_count == slbm_pkg::ShiftLoadCount) begin
                            sh_count = '0;
                            reg_loads++;
                            case (slbm_pkg::reg_sel_t'(a[14:13]))
                                slbm_pkg::SEL_CONTROL:  ctrl_q     = sh_bits;
                                slbm_pkg::SEL_CHR_LOW:  chr_lo     = sh_bits;
                                slbm_pkg::SEL_CHR_HIGH: chr_hi     = sh_bits;
                                slbm_pkg::SEL_PRG_BANK: rom_bank_q = sh_bits;
                            endcase
                        end
                    end
                end else begin
                    // 32K mode drops bank bit 0; 16K mode fixes one half
                    if (!ctrl_q[3]) begin
                        rom = {rom_bank_q[3:1], a[14:0]};
                    end else begin
                        if (!ctrl_q[2])
                            bank16 = (a >= 16'hc000) ? rom_bank_q[3:0] : 4'h0;
                        else
                            bank16 = (a >= 16'hc000) ? slbm_pkg::PrgLastBank
                                                     : rom_bank_q[3:0];
                        rom = {bank16, a[13:0]};
                    end
                    r.target      = slbm_pkg::TGT_PRG_ROM;
                    r.mapped_addr = rom & prg_mask;
                end
            end
        end else begin
            if (a < 16'h2000) begin
                if (!wr || chr_ram) begin
                    // 8K mode drops CHR low bank bit 0
                    if (!ctrl_q[4])
                        chr = {chr_lo[4:1], a[12:0]};
                    else
                        chr = {a[12] ? chr_hi : chr_lo, a[11:0]};
                    r.target       = slbm_pkg::TGT_CHR;
                    r.mapped_addr  = slbm_pkg::MapAddrW'(chr & chr_mask_q);
                    r.write_enable = wr;
                end
            end else if (a < slbm_pkg::PaletteBase) begin
                case (slbm_pkg::mirror_t'(ctrl_q[1:0]))
                    slbm_pkg::MIR_SINGLE_LOW:  nt = {1'b0, a[9:0]};
                    slbm_pkg::MIR_SINGLE_HIGH: nt = {1'b1, a[9:0]};
                    slbm_pkg::MIR_VERTICAL:    nt = {a[10], a[9:0]};
                    default:                   nt = {a[11], a[9:0]};
                endcase
                r.target       = slbm_pkg::TGT_NAMETABLE;
                r.mapped_addr  = slbm_pkg::MapAddrW'(nt);
                r.write_enable = wr;
            end else begin
                r.target       = slbm_pkg::TGT_PALETTE;
                r.mapped_addr  = slbm_pkg::MapAddrW'(a);
                r.write_enable = wr;
            end
        end
        if (r.write_enable)
            r.write_byte = b.write_value;
        return r;
    endfunction

    // Config register write, mirrored at the same edge
    task automatic write_cfg(input slbm_pkg::cfg_index_t idx,
                             input logic [slbm_pkg::CfgDataW-1:0] d);
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= d;
        @(posedge aclk);
        cfg_we <= 1'b0;
        case (idx)
            slbm_pkg::CFG_PRG_ROM_MASK: prg_mask   = d;
            slbm_pkg::CFG_CHR_MASK:     chr_mask_q = d[slbm_pkg::ChrAddrW-1:0];
            slbm_pkg::CFG_CHR_IS_RAM:   chr_ram    = d[0];
            default: ;
        endcase
    endtask

    // Send one access beat; queue its result on acceptance
    task automatic send_access(input slbm_pkg::in_beat_t b, input bit typed,
                               input slbm_pkg::out_beat_t want);
        int unsigned         gap;
        slbm_pkg::out_beat_t predicted;
        gap = send_idle ? $urandom_range(0, 10) : 0;
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= b;
        do @(posedge aclk); while (!s_ready);
        predicted = map_access(b);
        pending_results.push_back(typed ? want : predicted);
        sent_accesses++;
    endtask

    // Drop valid and let every queued result come back
    task automatic wait_idle();
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (DrainCycles) @(posedge aclk);
    endtask

    // Result side: random stalls, compare each beat with the oldest expectation
    initial begin
        slbm_pkg::out_beat_t want;
        int unsigned         stall;
        m_ready <= 1'b0;
        do @(posedge aclk); while (!aresetn);
        forever begin
            stall = recv_idle ? $urandom_range(0, 10) : 0;
            if (stall != 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            if (pending_results.size() == 0) begin
                bad_results++;
                if (bad_results <= 10)
                    $display("unexpected result beat: target %0d addr %h we %b byte %h",
                             m_data.target, m_data.mapped_addr, m_data.write_enable,
                             m_data.write_byte);
            end else begin
                want = pending_results.pop_front();
                checked_results++;
                if (m_data.target !== want.target ||
                    m_data.mapped_addr !== want.mapped_addr ||
                    m_data.write_enable !== want.write_enable ||
                    m_data.write_byte !== want.write_byte) begin
                    bad_results++;
                    if (bad_results <= 10)
                        $display({"result %0d: got target %0d addr %h we %b byte %h,",
                                  " want target %0d addr %h we %b byte %h"},
                                 checked_results, m_data.target, m_data.mapped_addr,
                                 m_data.write_enable, m_data.write_byte, want.target,
                                 want.mapped_addr, want.write_enable, want.write_byte);
                end
            end
        end
    end

    // Stimulus
    initial begin
        slbm_pkg::in_beat_t            b;
        logic [slbm_pkg::CfgDataW-1:0] pm;
        logic [slbm_pkg::CfgDataW-1:0] cm;
        logic                          ram;
        int unsigned                   pick;
        s_valid   <= 1'b0;
        s_data    <= '0;
        cfg_we    <= 1'b0;
        cfg_index <= slbm_pkg::CFG_PRG_ROM_MASK;
        cfg_wdata <= '0;
        aresetn   <= 1'b0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // directed table at power-up settings
        for (int i = 0; i < DrillCount; i++)
            send_access(drills[i].beat, drills[i].typed, drills[i].want);

        for (int p = 0; p < NumPhases; p++) begin
            wait_idle();
            // mask settings: extremes, then two fixed sizes, then random sizes or values
            case (p)
                0: begin pm = 18'h3ffff; cm = 18'h1ffff; ram = 1'b1; end
                1: begin pm = 18'h00000; cm = 18'h00000; ram = 1'b0; end
                2: begin pm = 18'h0ffff; cm = 18'h07fff; ram = 1'b1; end
                3: begin pm = 18'h1ffff; cm = 18'h01fff; ram = 1'b0; end
                default: begin
                    if ($urandom_range(0, 1)) begin
                        pm = slbm_pkg::CfgDataW'((32'd1 << $urandom_range(0, 18)) - 1);
                        cm = slbm_pkg::CfgDataW'((32'd1 << $urandom_range(0, 17)) - 1);
                    end else begin
                        pm = slbm_pkg::CfgDataW'($urandom);
                        cm = slbm_pkg::CfgDataW'($urandom_range(0, 17'h1ffff));
                    end
                    ram = 1'($urandom_range(0, 1));
                    write_cfg(slbm_pkg::CFG_NONE, slbm_pkg::CfgDataW'($urandom));
                end
            endcase
            write_cfg(slbm_pkg::CFG_PRG_ROM_MASK, pm);
            write_cfg(slbm_pkg::CFG_CHR_MASK, cm);
            write_cfg(slbm_pkg::CFG_CHR_IS_RAM, slbm_pkg::CfgDataW'(ram));
            // first phase runs flat out, second fully throttled, rest mixed
            send_idle = (p == 0) ? 1'b0 : (p == 1) ? 1'b1 : bit'($urandom_range(0, 1));
            recv_idle = (p == 0) ? 1'b0 : (p == 1) ? 1'b1 : bit'($urandom_range(0, 1));

            for (int n = 0; n < PhaseAccesses; n++) begin
                pick          = $urandom_range(0, 99);
                b.write_value = 8'($urandom_range(0, 255));
                if (pick < 30) begin
                    // serial data bit
                    b.kind        = slbm_pkg::KIND_CPU_WRITE;
                    b.bus_addr    = 16'h8000 | slbm_pkg::AddrW'($urandom_range(0, 16'h7fff));
                    b.write_value = 8'($urandom_range(0, 127));
                end else if (pick < 33) begin
                    // serial reset
                    b.kind        = slbm_pkg::KIND_CPU_WRITE;
                    b.bus_addr    = 16'h8000 | slbm_pkg::AddrW'($urandom_range(0, 16'h7fff));
                    b.write_value = 8'h80 | 8'($urandom_range(0, 127));
                end else if (pick < 90) begin
                    // region-weighted access
                    b.kind = slbm_pkg::kind_t'($urandom_range(0, 3));
                    if (b.kind == slbm_pkg::KIND_CPU_READ ||
                        b.kind == slbm_pkg::KIND_CPU_WRITE) begin
                        case ($urandom_range(0, 2))
                            0: b.bus_addr = slbm_pkg::AddrW'($urandom_range(0, 16'h5fff));
                            1: b.bus_addr =
                                   slbm_pkg::AddrW'($urandom_range(16'h6000, 16'h7fff));
                            default: b.bus_addr =
                                   slbm_pkg::AddrW'($urandom_range(16'h8000, 16'hffff));
                        endcase
                    end else begin
                        case ($urandom_range(0, 2))
                            0: b.bus_addr = slbm_pkg::AddrW'($urandom_range(0, 16'h1fff));
                            1: b.bus_addr =
                                   slbm_pkg::AddrW'($urandom_range(16'h2000, 16'h3eff));
                            default: b.bus_addr =
                                   slbm_pkg::AddrW'($urandom_range(16'h3f00, 16'hffff));
                        endcase
                    end
                end else begin
                    b.kind     = slbm_pkg::kind_t'($urandom_range(0, 3));
                    b.bus_addr = slbm_pkg::AddrW'($urandom_range(0, 16'hffff));
                end
                send_access(b, 1'b0, '0);
            end
        end

        wait_idle();
        $display("%0d accesses over %0d mask settings, %0d results checked",
                 sent_accesses, NumPhases + 1, checked_results);
        $display("%0d serial bank register loads, %0d failing beats", reg_loads, bad_results);
        if (bad_results == 0)
            $display("serial_loaded_bank_mapper: match");
        else
            $display("serial_loaded_bank_mapper: mismatch");
        $finish;
    end

endmodule

// ===== serial_loaded_bank_mapper.f =====
sv/slbm_pkg.sv
sv/serial_loaded_bank_mapper.sv
tb/tb_top.sv
